[design/clr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// log capture ring. No dependencies.
`timescale 1ns / 1ps

package clr_pkg;

    localparam int LOG_DEPTH = 4096;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OFF_W     = 12;
    localparam int RET_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int CMP_W     = (CNT_W > OFF_W) ? CNT_W : OFF_W;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_RD   = 1'b1;

    typedef enum logic [1:0] {
        SRC_IN = 2'd0,
        SRC_CR = 2'd1,
        SRC_LF = 2'd2
    } t_src;

    typedef struct packed {
        logic capture;
        logic store;
        t_src src;
        logic emit_tx;
        logic tx_last;
        logic rd_start;
        logic emit_rd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic op_read;
        logic byte_is_lf;
    } t_stat;

endpackage

[design/crlf_capture_log_ring.sv]
// Log byte transmitter with CR/LF expansion and a wrapping capture ring.
// An append result is registered as its transaction is accepted; a read first
// loads the registered ring read port and registers its result in S_RD.
// Throughput: one plain byte per cycle; a line feed also passes S_LF (two ring
// writes on one write port), a read S_RD; all stall while the result is held.
// Reset (synchronous, active low) clears write index, retained count and state;
// ring contents are not cleared.
`timescale 1ns / 1ps

module crlf_capture_log_ring import clr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [OFF_W-1:0]  i_offset,
    input  logic              i_end_of_run,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_read_valid,
    output logic [RET_W-1:0]  o_retained,
    output logic              o_last,
    output logic              o_run_end
);

    t_cmd  cmd;
    t_stat stat;

    clr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_offset     (i_offset),
        .i_end_of_run (i_end_of_run),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_read_valid (o_read_valid),
        .o_retained   (o_retained),
        .o_last       (o_last),
        .o_run_end    (o_run_end)
    );

endmodule

[design/clr_ctrl.sv]
// Sequencing state machine for the log capture ring.
// Depends on clr_pkg; drives commands into clr_dpath.
`timescale 1ns / 1ps

module clr_ctrl import clr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LF   = 3'b010,
        S_RD   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.src  = SRC_IN;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.op_read) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD;
                    end else if (i_stat.byte_is_lf) begin
                        // CR goes first, LF follows next free slot
                        o_cmd.store   = 1'b1;
                        o_cmd.src     = SRC_CR;
                        o_cmd.emit_tx = 1'b1;
                        n_state       = S_LF;
                    end else begin
                        o_cmd.store   = 1'b1;
                        o_cmd.emit_tx = 1'b1;
                        o_cmd.tx_last = 1'b1;
                    end
                end
            end
            S_LF: begin
                if (i_stat.out_free) begin
                    o_cmd.store   = 1'b1;
                    o_cmd.src     = SRC_LF;
                    o_cmd.emit_tx = 1'b1;
                    o_cmd.tx_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_RD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/clr_dpath.sv]
// Capture ring memory, write index, retained count and result register.
// Depends on clr_pkg; commanded by clr_ctrl.
`timescale 1ns / 1ps

module clr_dpath import clr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [OFF_W-1:0]  i_offset,
    input  logic              i_end_of_run,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_read_valid,
    output logic [RET_W-1:0]  o_retained,
    output logic              o_last,
    output logic              o_run_end
);

    logic [BYTE_W-1:0] r_mem [LOG_DEPTH];

    logic [IDX_W-1:0]  r_widx;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_rend;
    logic              r_rd_hit;
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_out_valid;
    logic              r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic              r_rvalid;
    logic [RET_W-1:0]  r_ret;
    logic              r_last;
    logic              r_run_end;

    logic              rend_now;
    logic              full;
    logic              rd_hit;
    logic [IDX_W-1:0]  rd_start;
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] wr_byte;

    assign full     = (r_cnt == CNT_W'(LOG_DEPTH));
    assign n_cnt    = full ? r_cnt : r_cnt + CNT_W'(1);
    assign rend_now = i_cmd.capture ? i_end_of_run : r_rend;
    assign rd_hit   = (CMP_W'(i_offset) < CMP_W'(r_cnt));
    // oldest byte sits at index 0 until the ring has wrapped
    assign rd_start = full ? r_widx : '0;
    assign rd_addr  = rd_start + IDX_W'(i_offset);

    always_comb begin
        case (i_cmd.src)
            SRC_CR:  wr_byte = CH_CR;
            SRC_LF:  wr_byte = CH_LF;
            default: wr_byte = i_data_byte;
        endcase
    end

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.op_read    = (i_op == OP_READ);
    assign o_stat.byte_is_lf = (i_data_byte == CH_LF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_widx] <= wr_byte;
        end
        if (i_cmd.rd_start && rd_hit) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_widx <= r_widx + IDX_W'(1);
                r_cnt  <= n_cnt;
            end
            if (i_cmd.emit_tx || i_cmd.emit_rd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rend   <= i_end_of_run;
            r_rd_hit <= rd_hit;
        end
        if (i_cmd.emit_tx) begin
            r_kind    <= KIND_TX;
            r_byte    <= wr_byte;
            r_rvalid  <= 1'b0;
            r_ret     <= RET_W'(n_cnt);
            r_last    <= i_cmd.tx_last;
            r_run_end <= i_cmd.tx_last && rend_now;
        end else if (i_cmd.emit_rd) begin
            r_kind    <= KIND_RD;
            r_byte    <= r_rd_hit ? r_rd_data : '0;
            r_rvalid  <= r_rd_hit;
            r_ret     <= RET_W'(r_cnt);
            r_last    <= 1'b1;
            r_run_end <= r_rend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_read_valid = r_rvalid;
    assign o_retained   = r_ret;
    assign o_last       = r_last;
    assign o_run_end    = r_run_end;

endmodule

[design/clr_checker.sv]
// Port-level checks for crlf_capture_log_ring, attached by bind.
// Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_checker import clr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_kind,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_read_valid,
    input logic [RET_W-1:0]  o_retained,
    input logic              o_last,
    input logic              o_run_end
);

    // held result keeps its payload until the transaction completes
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_retained) && $stable(o_last))
        else $error("result changed while stalled");

    // only the carriage return of an expanded line feed is a non-final result
    a_nonlast_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_kind == KIND_TX && o_out_byte == CH_CR
            && !o_run_end)
        else $error("unexpected non-final result");

    a_tx_no_rvalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_TX |-> !o_read_valid && o_retained != '0)
        else $error("transmit result with read flag or empty count");

    a_rd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> o_kind == KIND_RD && o_retained != '0)
        else $error("valid read with nothing retained");

    // a carriage return result is followed by its line feed
    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_out_byte == CH_LF
            && o_last && o_retained == $past(o_retained) + RET_W'(1)
            || $past(o_retained) == RET_W'(LOG_DEPTH))
        else $error("line feed did not follow carriage return");

endmodule

bind crlf_capture_log_ring clr_checker u_clr_checker (.*);
